// ===== hdl/mandelbrot_escape_time_pixel_defines.svh =====
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define MET_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define MET_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/met_pkg.sv =====
`default_nettype none
package met_pkg;

  localparam int WIDTH     = 1024;
  localparam int HEIGHT    = 1024;
  localparam int FRAC_BITS = 28;
  localparam int SHIFT_X   = $clog2(WIDTH);
  localparam int SHIFT_Y   = $clog2(HEIGHT);

  localparam logic [31:0] ESC_STEP_COLOR = 32'h0032_32FF;
  localparam logic [31:0] INSIDE_COLOR   = 32'h000E_0E0E;
  localparam logic signed [63:0] ESC_MAG = 64'sd4 <<< FRAC_BITS;

  typedef enum logic [2:0] {
    REG_X_MIN      = 3'd0,
    REG_X_MAX      = 3'd1,
    REG_Y_MIN      = 3'd2,
    REG_Y_MAX      = 3'd3,
    REG_BASE_COLOR = 3'd4,
    REG_ITER_LIMIT = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_MUL,
    ST_ADD,
    ST_RUN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  pixel_col;
    logic [9:0]  pixel_row;
    logic [31:0] pixel_color;
    logic        escaped;
  } out_word_t;

  typedef struct packed {
    logic              valid;
    logic              done;
    logic              esc;
    logic [9:0]        k;
    logic signed [31:0] zr;
    logic signed [31:0] zi;
  } token_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    begin
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
        sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
        sat32 = 32'sh8000_0000;
      end else begin
        sat32 = v[31:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/met_cell.sv =====
`default_nettype none
module met_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire met_pkg::token_t    tin,
  input  wire logic signed [31:0] c_re,
  input  wire logic signed [31:0] c_im,
  input  wire logic [9:0]         limit,
  output met_pkg::token_t         tout
);
  import met_pkg::*;

  logic               v1;
  logic               d1;
  logic               e1;
  logic [9:0]         k1;
  logic signed [63:0] prr;
  logic signed [63:0] pii;
  logic signed [63:0] pri;

  logic signed [63:0] rr_s;
  logic signed [63:0] ii_s;
  logic signed [63:0] ri_s;
  logic signed [63:0] mag;
  logic signed [31:0] rr32;
  logic signed [31:0] ii32;
  logic signed [31:0] ri32;
  logic signed [31:0] zr_n;
  logic signed [31:0] zi_n;
  logic               esc_now;
  logic               more;
  token_t             tout_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= tin.valid;
    end
    d1  <= tin.done;
    e1  <= tin.esc;
    k1  <= tin.k;
    prr <= tin.zr * tin.zr;
    pii <= tin.zi * tin.zi;
    pri <= tin.zr * tin.zi;
  end

  always_comb begin
    rr_s    = prr >>> FRAC_BITS;
    ii_s    = pii >>> FRAC_BITS;
    ri_s    = pri >>> (FRAC_BITS - 1);
    mag     = rr_s + ii_s;
    esc_now = (k1 != 10'd0) && (mag > ESC_MAG);
    more    = ({1'b0, k1} + 11'd1) < {1'b0, limit};
    rr32    = sat32(rr_s);
    ii32    = sat32(ii_s);
    ri32    = sat32(ri_s);
    zr_n    = sat32(64'(rr32) - 64'(ii32) + 64'(c_re));
    zi_n    = sat32(64'(ri32) + 64'(c_im));

    tout_next.valid = v1;
    tout_next.done  = d1;
    tout_next.esc   = e1;
    tout_next.k     = k1;
    tout_next.zr    = zr_n;
    tout_next.zi    = zi_n;
    if (!d1) begin
      if (esc_now) begin
        tout_next.done = 1'b1;
        tout_next.esc  = 1'b1;
      end else if (more) begin
        tout_next.k = k1 + 10'd1;
      end else begin
        tout_next.done = 1'b1;
        tout_next.esc  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else begin
      tout.valid <= tout_next.valid;
    end
    tout.done <= tout_next.done;
    tout.esc  <= tout_next.esc;
    tout.k    <= tout_next.k;
    tout.zr   <= tout_next.zr;
    tout.zi   <= tout_next.zi;
  end

endmodule
`default_nettype wire

// ===== hdl/mandelbrot_escape_time_pixel.sv =====
// Mandelbrot escape-time colouring of one pixel in signed Q4.28 fixed point.
// The input channel carries a word with the pixel column and row; the output
// channel returns the same coordinates with the 32-bit colour and an escape
// flag. The configuration channel writes the view edges, the colour base and
// the iteration limit, and is always ready; write it only while idle.
// One pixel is worked on at a time. Mapping runs through the span, multiply
// and add states, then the orbit runs round a ring of two iteration cells,
// each a two-stage pipeline of a squaring multiplier and an update adder.
// The finished word sits in an output register, so a new pixel is accepted
// while it waits; if the receiver stalls, the next result is held in the
// finish state until the register is free, and the input stays blocked.
// Reset restores the default view and limit 100 and empties the ring and the
// output register.
`default_nettype none
module mandelbrot_escape_time_pixel (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire met_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output met_pkg::out_word_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import met_pkg::*;

  logic signed [31:0] x_min;
  logic signed [31:0] x_max;
  logic signed [31:0] y_min;
  logic signed [31:0] y_max;
  logic [31:0]        base_color;
  logic [9:0]         iteration_limit;

  state_t             state;
  state_t             state_next;
  logic [9:0]         col;
  logic [9:0]         row;
  logic signed [32:0] step_x;
  logic signed [32:0] step_y;
  logic signed [43:0] prod_x;
  logic signed [43:0] prod_y;
  logic signed [31:0] c_re;
  logic signed [31:0] c_im;
  logic [9:0]         res_k;
  logic               res_esc;

  token_t             init_tok;
  token_t             c0_in;
  token_t             c0_out;
  token_t             c1_in;
  token_t             c1_out;
  logic               hit0;
  logic               hit1;
  logic               load_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min           <= -32'sd536870912;
      x_max           <= 32'sd268435456;
      y_min           <= -32'sd402653184;
      y_max           <= 32'sd402653184;
      base_color      <= '0;
      iteration_limit <= 10'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_X_MIN:      x_min <= cfg_data;
        REG_X_MAX:      x_max <= cfg_data;
        REG_Y_MIN:      y_min <= cfg_data;
        REG_Y_MAX:      y_max <= cfg_data;
        REG_BASE_COLOR: base_color <= cfg_data;
        REG_ITER_LIMIT: iteration_limit <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign hit0 = c0_out.valid && c0_out.done;
  assign hit1 = c1_out.valid && c1_out.done;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SPAN;
      ST_SPAN: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = ST_RUN;
      ST_RUN:  if (hit0 || hit1) state_next = ST_FIN;
      ST_FIN:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == ST_IDLE);
    load_out       = (state == ST_FIN) && (!out_valid || out_ready);
    init_tok.valid = 1'b1;
    init_tok.done  = 1'b0;
    init_tok.esc   = 1'b0;
    init_tok.k     = '0;
    init_tok.zr    = '0;
    init_tok.zi    = '0;
    c0_in          = c1_out;
    c0_in.valid    = (state == ST_RUN) && c1_out.valid && !c1_out.done;
    if (state == ST_ADD) begin
      c0_in = init_tok;
    end
    c1_in          = c0_out;
    c1_in.valid    = (state == ST_RUN) && c0_out.valid && !c0_out.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      col <= in_data.col;
      row <= in_data.row;
    end
    if (state == ST_SPAN) begin
      step_x <= (33'(x_max) - 33'(x_min)) >>> SHIFT_X;
      step_y <= (33'(y_max) - 33'(y_min)) >>> SHIFT_Y;
    end
    if (state == ST_MUL) begin
      prod_x <= $signed({1'b0, col}) * step_x;
      prod_y <= $signed({1'b0, row}) * step_y;
    end
    if (state == ST_ADD) begin
      c_re <= sat32(64'(x_min) + 64'(prod_x));
      c_im <= sat32(64'(y_max) - 64'(prod_y));
    end
    if (state == ST_RUN) begin
      if (hit0) begin
        res_k   <= c0_out.k;
        res_esc <= c0_out.esc;
      end else begin
        res_k   <= c1_out.k;
        res_esc <= c1_out.esc;
      end
    end
    if (load_out) begin
      out_data.pixel_col   <= col;
      out_data.pixel_row   <= row;
      out_data.escaped     <= res_esc;
      out_data.pixel_color <= res_esc ? base_color + 32'(ESC_STEP_COLOR * res_k)
                                      : INSIDE_COLOR;
    end
  end

  met_cell u_cell0 (
    .clk  (clk),
    .rst  (rst),
    .tin  (c0_in),
    .c_re (c_re),
    .c_im (c_im),
    .limit(iteration_limit),
    .tout (c0_out)
  );

  met_cell u_cell1 (
    .clk  (clk),
    .rst  (rst),
    .tin  (c1_in),
    .c_re (c_re),
    .c_im (c_im),
    .limit(iteration_limit),
    .tout (c1_out)
  );

endmodule
`default_nettype wire

// ===== hdl/met_checker.sv =====
`default_nettype none
`include "mandelbrot_escape_time_pixel_defines.svh"
module met_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire met_pkg::in_word_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire met_pkg::out_word_t out_data,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready,
  input wire logic [2:0]         cfg_index,
  input wire logic [31:0]        cfg_data
);
  import met_pkg::*;

  `MET_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `MET_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
  `MET_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `MET_ASSERT_IMPL(a_inside_color, out_valid && !out_data.escaped,
                   out_data.pixel_color == INSIDE_COLOR)

endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker (.*);
`default_nettype wire
